FILE: rtl/rsw_pkg.sv
// ----------------------------------------------------------------------------
// rsw_pkg: shared types and constants for the range sensor point mapper
// Sensor codes, register indexes, mount geometry and the types passed
// between the front classifier, the queue and the back-end pipeline.
// ----------------------------------------------------------------------------
package rsw_pkg;

	// sizes
	localparam int RSW_SENSORS    = 5;
	localparam int RSW_SENSOR_W   = 3;
	localparam int RSW_DIST_W     = 12;
	localparam int RSW_RAW_W      = 16;
	localparam int RSW_SLOT_W     = 10;
	localparam int RSW_COORD_W    = 16;
	localparam int RSW_FIFO_DEPTH = 4;
	localparam int RSW_FIFO_PTR_W = $clog2(RSW_FIFO_DEPTH);
	localparam int RSW_FIFO_CNT_W = $clog2(RSW_FIFO_DEPTH + 1);

	// sensor codes, left side to right side
	localparam logic [RSW_SENSOR_W-1:0] SENSOR_LEFT       = 3'd0;
	localparam logic [RSW_SENSOR_W-1:0] SENSOR_FRONT_LEFT = 3'd1;
	localparam logic [RSW_SENSOR_W-1:0] SENSOR_FRONT      = 3'd2;
	localparam logic [RSW_SENSOR_W-1:0] SENSOR_FRONT_RGT  = 3'd3;
	localparam logic [RSW_SENSOR_W-1:0] SENSOR_RIGHT      = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_POSE_X    = 3'd0;
	localparam logic [2:0] REG_POSE_Y    = 3'd1;
	localparam logic [2:0] REG_COS       = 3'd2;
	localparam logic [2:0] REG_SIN       = 3'd3;
	localparam logic [2:0] REG_RANGE_MIN = 3'd4;
	localparam logic [2:0] REG_RANGE_MAX = 3'd5;

	// mount geometry, millimeters
	localparam logic [15:0] DIAG_Q16   = 16'd46341;   // sqrt(2)/2 in Q0.16
	localparam int          OFS_SIDE_X = 310;
	localparam int          OFS_SIDE_Y = 230;
	localparam int          OFS_DIAG_X = 180;
	localparam int          OFS_DIAG_Y = 330;
	localparam int          OFS_FRONT  = 380;

	// configuration register file contents
	typedef struct packed {
		logic signed [15:0] pose_x;
		logic signed [15:0] pose_y;
		logic signed [15:0] cos_heading;
		logic signed [15:0] sin_heading;
		logic [11:0]        range_min;
		logic [11:0]        range_max;
	} rsw_cfg_t;

	// one classified reading, front to back
	typedef struct packed {
		logic [RSW_SENSOR_W-1:0] sensor;
		logic [RSW_DIST_W-1:0]   dist_mm;
		logic [RSW_SLOT_W-1:0]   slot;
		logic                    ok;
	} rsw_item_t;

endpackage

FILE: rtl/rsw_front.sv
// ----------------------------------------------------------------------------
// rsw_front: reading classifier
// Accepts readings, checks them against the valid range, keeps the last
// good distance per sensor, tags each point with its ring slot and pushes
// it into the queue. Readings with an unknown sensor index are dropped.
// ----------------------------------------------------------------------------
module rsw_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsw_pkg::rsw_cfg_t             cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rsw_pkg::RSW_SENSOR_W-1:0] sensor_index,
	input  logic [rsw_pkg::RSW_RAW_W-1:0] distance,
	input  logic                          q_full,
	output logic                          q_push,
	output rsw_pkg::rsw_item_t            q_item
);
	import rsw_pkg::*;

	logic [RSW_DIST_W-1:0] held_q [RSW_SENSORS];
	logic [RSW_SLOT_W-1:0] slot_q;
	logic                  beat;
	logic                  known;
	logic                  in_range;

	assign in_ready = !q_full;
	assign beat     = in_valid && in_ready;
	assign known    = (sensor_index <= SENSOR_RIGHT);

	// range check on the full raw value
	assign in_range = (distance >= {4'b0, cfg.range_min}) &&
	                  (distance <= {4'b0, cfg.range_max});

	// classified item
	always_comb begin
		q_push        = beat && known;
		q_item.sensor = sensor_index;
		q_item.ok     = in_range;
		q_item.slot   = slot_q;
		if (in_range) begin
			q_item.dist_mm = distance[RSW_DIST_W-1:0];
		end else begin
			q_item.dist_mm = held_q[sensor_index];
		end
	end

	// held distances and slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RSW_SENSORS; i++) begin
				held_q[i] <= '0;
			end
			slot_q <= '0;
		end else if (q_push) begin
			if (in_range) begin
				held_q[sensor_index] <= distance[RSW_DIST_W-1:0];
			end
			slot_q <= slot_q + 1'b1;
		end
	end

endmodule

FILE: rtl/rsw_fifo.sv
// ----------------------------------------------------------------------------
// rsw_fifo: short item queue
// Decouples the classifier from the transform pipeline so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
module rsw_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rsw_pkg::rsw_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output rsw_pkg::rsw_item_t head
);
	import rsw_pkg::*;

	rsw_item_t                 mem_q [RSW_FIFO_DEPTH];
	logic [RSW_FIFO_PTR_W-1:0] wr_ptr_q;
	logic [RSW_FIFO_PTR_W-1:0] rd_ptr_q;
	logic [RSW_FIFO_CNT_W-1:0] count_q;

	assign full  = (count_q == RSW_FIFO_CNT_W'(RSW_FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/rsw_back.sv
// ----------------------------------------------------------------------------
// rsw_back: robot-to-world transform pipeline
// Diagonal scaling, mount geometry, rotation products, floor shift and
// translation with saturation, then the output register.
// ----------------------------------------------------------------------------
module rsw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rsw_pkg::rsw_cfg_t   cfg,
	input  logic                q_empty,
	input  rsw_pkg::rsw_item_t  q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [rsw_pkg::RSW_COORD_W-1:0] world_x,
	output logic signed [rsw_pkg::RSW_COORD_W-1:0] world_y,
	output logic [rsw_pkg::RSW_SLOT_W-1:0]          slot,
	output logic                                    accepted
);
	import rsw_pkg::*;

	localparam int GEO_W  = 14;
	localparam int PROD_W = GEO_W + 16;
	localparam int SUM_W  = PROD_W + 1;
	localparam int ROT_W  = SUM_W - 14;
	localparam int POS_W  = ROT_W + 1;

	typedef struct packed {
		logic [RSW_SLOT_W-1:0] slot;
		logic                  ok;
	} rsw_tag_t;

	logic adv;

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;

	// payload
	rsw_item_t                 item_s1;
	logic [RSW_SENSOR_W-1:0]   sensor_s2;
	logic [RSW_DIST_W-1:0]     d_s2;
	logic [RSW_DIST_W-1:0]     h_s2;
	rsw_tag_t                  tag_s2, tag_s3, tag_s4, tag_s5, tag_q;
	logic signed [GEO_W-1:0]   x_s3, y_s3;
	logic signed [PROD_W-1:0]  xc_s4, ys_s4, xs_s4, yc_s4;
	logic signed [ROT_W-1:0]   rx_s5, ry_s5;
	logic signed [RSW_COORD_W-1:0] wx_q, wy_q;

	logic [27:0]               diag_prod;
	logic signed [GEO_W-1:0]   x_geo, y_geo;
	logic signed [GEO_W-1:0]   d_sx, h_sx;
	logic signed [SUM_W-1:0]   sum_x, sum_y;
	logic signed [POS_W-1:0]   pos_x, pos_y;
	logic signed [RSW_COORD_W-1:0] sat_x, sat_y;

	// whole pipeline moves unless the output beat is stalled
	assign adv   = !out_valid_q || out_ready;
	assign q_pop = adv && !q_empty;

	// diagonal scale, floor(d * sqrt(2)/2)
	assign diag_prod = 28'(item_s1.dist_mm) * 28'(DIAG_Q16);

	// mount geometry in the robot frame
	assign d_sx = $signed({2'b0, d_s2});
	assign h_sx = $signed({2'b0, h_s2});
	always_comb begin
		case (sensor_s2)
			SENSOR_LEFT: begin
				x_geo = -d_sx - GEO_W'(OFS_SIDE_X);
				y_geo = GEO_W'(OFS_SIDE_Y);
			end
			SENSOR_FRONT_LEFT: begin
				x_geo = -h_sx - GEO_W'(OFS_DIAG_X);
				y_geo = h_sx + GEO_W'(OFS_DIAG_Y);
			end
			SENSOR_FRONT: begin
				x_geo = '0;
				y_geo = d_sx + GEO_W'(OFS_FRONT);
			end
			SENSOR_FRONT_RGT: begin
				x_geo = h_sx + GEO_W'(OFS_DIAG_X);
				y_geo = h_sx + GEO_W'(OFS_DIAG_Y);
			end
			default: begin
				x_geo = d_sx + GEO_W'(OFS_SIDE_X);
				y_geo = GEO_W'(OFS_SIDE_Y);
			end
		endcase
	end

	// rotation sums; the arithmetic shift is a floor divide by 2^14
	assign sum_x = SUM_W'(xc_s4) - SUM_W'(ys_s4);
	assign sum_y = SUM_W'(xs_s4) + SUM_W'(yc_s4);

	// translation and saturation
	assign pos_x = POS_W'(rx_s5) + POS_W'(cfg.pose_x);
	assign pos_y = POS_W'(ry_s5) + POS_W'(cfg.pose_y);

	always_comb begin
		if (pos_x > POS_W'(32767)) begin
			sat_x = 16'sh7fff;
		end else if (pos_x < -POS_W'(32768)) begin
			sat_x = -16'sh8000;
		end else begin
			sat_x = pos_x[RSW_COORD_W-1:0];
		end
		if (pos_y > POS_W'(32767)) begin
			sat_y = 16'sh7fff;
		end else if (pos_y < -POS_W'(32768)) begin
			sat_y = -16'sh8000;
		end else begin
			sat_y = pos_y[RSW_COORD_W-1:0];
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1    <= q_head;
			sensor_s2  <= item_s1.sensor;
			d_s2       <= item_s1.dist_mm;
			h_s2       <= diag_prod[27:16];
			tag_s2     <= '{slot: item_s1.slot, ok: item_s1.ok};
			x_s3       <= x_geo;
			y_s3       <= y_geo;
			tag_s3     <= tag_s2;
			xc_s4      <= x_s3 * cfg.cos_heading;
			ys_s4      <= y_s3 * cfg.sin_heading;
			xs_s4      <= x_s3 * cfg.sin_heading;
			yc_s4      <= y_s3 * cfg.cos_heading;
			tag_s4     <= tag_s3;
			rx_s5      <= sum_x[SUM_W-1:14];
			ry_s5      <= sum_y[SUM_W-1:14];
			tag_s5     <= tag_s4;
			wx_q       <= sat_x;
			wy_q       <= sat_y;
			tag_q      <= tag_s5;
		end
	end

	assign out_valid = out_valid_q;
	assign world_x   = wx_q;
	assign world_y   = wy_q;
	assign slot      = tag_q.slot;
	assign accepted  = tag_q.ok;

endmodule

FILE: rtl/range_sensor_to_world_points.sv
// ----------------------------------------------------------------------------
// range_sensor_to_world_points: distance readings to world-frame wall points
// Points leave from the output register. Throughput is one reading per
// cycle while the output is not stalled, set by the 4-entry queue and
// the stall-together transform pipeline. Readings with an unknown
// sensor index give no point. Reset clears held distances, the slot
// counter and the queue, and loads pose, heading and range defaults.
// ----------------------------------------------------------------------------
module range_sensor_to_world_points (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// readings
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [rsw_pkg::RSW_SENSOR_W-1:0] sensor_index,
	input  logic [rsw_pkg::RSW_RAW_W-1:0]    distance,
	// points
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [rsw_pkg::RSW_COORD_W-1:0] world_x,
	output logic signed [rsw_pkg::RSW_COORD_W-1:0] world_y,
	output logic [rsw_pkg::RSW_SLOT_W-1:0]          slot,
	output logic        accepted
);
	import rsw_pkg::*;

	rsw_cfg_t  cfg_q;
	logic      q_full, q_empty, q_push, q_pop;
	rsw_item_t q_item, q_head;

	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pose_x      <= 16'sd90;
			cfg_q.pose_y      <= 16'sd90;
			cfg_q.cos_heading <= -16'sd16384;
			cfg_q.sin_heading <= 16'sd0;
			cfg_q.range_min   <= 12'd1;
			cfg_q.range_max   <= 12'd2000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POSE_X:    cfg_q.pose_x      <= cfg_data;
				REG_POSE_Y:    cfg_q.pose_y      <= cfg_data;
				REG_COS:       cfg_q.cos_heading <= cfg_data;
				REG_SIN:       cfg_q.sin_heading <= cfg_data;
				REG_RANGE_MIN: cfg_q.range_min   <= cfg_data[11:0];
				REG_RANGE_MAX: cfg_q.range_max   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	rsw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sensor_index (sensor_index),
		.distance     (distance),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_item)
	);

	rsw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	rsw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.world_x   (world_x),
		.world_y   (world_y),
		.slot      (slot),
		.accepted  (accepted)
	);

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: range_sensor_to_world_points
// Drives distance readings from the five mount positions through a series of
// pose and range settings under varied idling, back-pressure and a long
// output hold-off. A bit-accurate point predictor computes each point and
// checks every output beat against it, field by field, in arrival order.
// ----------------------------------------------------------------------------
module testbench;
	import rsw_pkg::*;

	localparam int DRAIN_CYCLES   = 12;   // output latency plus margin
	localparam int RX_HOLD_CYCLES = 80;
	localparam int PHASES         = 8;
	localparam int PHASE_READINGS = 140;

	// one predicted world point
	typedef struct {
		logic signed [15:0] wx;
		logic signed [15:0] wy;
		logic [9:0]         slot;
		logic               acc;
	} world_point_t;

	// point predictor: own copy of registers, held distances and slot counter
	class world_point_tracker;
		logic signed [15:0] pose_x, pose_y, cos_h, sin_h;
		logic [11:0]        range_lo, range_hi;
		logic [11:0]        held [RSW_SENSORS];
		logic [9:0]         next_slot;
		world_point_t       expected_points [$];
		int                 failures;

		function new();
			pose_x    = 16'sd90;
			pose_y    = 16'sd90;
			cos_h     = -16'sd16384;
			sin_h     = 16'sd0;
			range_lo  = 12'd1;
			range_hi  = 12'd2000;
			foreach (held[i]) held[i] = '0;
			next_slot = '0;
			failures  = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_POSE_X:    pose_x   = val;
				REG_POSE_Y:    pose_y   = val;
				REG_COS:       cos_h    = val;
				REG_SIN:       sin_h    = val;
				REG_RANGE_MIN: range_lo = val[11:0];
				REG_RANGE_MAX: range_hi = val[11:0];
				default: ;
			endcase
		endfunction

		function logic [15:0] clamp16(longint v);
			if (v > 32767) return 16'h7FFF;
			if (v < -32768) return 16'h8000;
			return v[15:0];
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		// accepted reading: update held distance and queue the world point
		function void note_reading(logic [2:0] s, logic [15:0] raw);
			longint       d, h, x, y, c, sn;
			world_point_t p;
			if (s >= RSW_SENSORS) return;   // unknown sensor: no point, no state change
			p.acc = (raw >= range_lo) && (raw <= range_hi);
			if (p.acc) held[s] = raw[11:0];
			d = held[s];
			h = (d * longint'(DIAG_Q16)) >>> 16;
			case (s)
				SENSOR_LEFT: begin
					x = -d - OFS_SIDE_X;
					y = OFS_SIDE_Y;
				end
				SENSOR_FRONT_LEFT: begin
					x = -h - OFS_DIAG_X;
					y = h + OFS_DIAG_Y;
				end
				SENSOR_FRONT: begin
					x = 0;
					y = d + OFS_FRONT;
				end
				SENSOR_FRONT_RGT: begin
					x = h + OFS_DIAG_X;
					y = h + OFS_DIAG_Y;
				end
				default: begin
					x = d + OFS_SIDE_X;
					y = OFS_SIDE_Y;
				end
			endcase
			c  = cos_h;
			sn = sin_h;
			// rotate in Q1.14 with floor shift, translate, saturate
			p.wx = clamp16(longint'(pose_x) + ((x * c - y * sn) >>> 14));
			p.wy = clamp16(longint'(pose_y) + ((x * sn + y * c) >>> 14));
			p.slot = next_slot;
			next_slot = next_slot + 10'd1;
			expected_points.push_back(p);
		endfunction

		// compare one output beat with the oldest predicted point
		function void check_point(logic signed [15:0] wx, logic signed [15:0] wy,
				logic [9:0] sl, logic acc);
			world_point_t p;
			if (expected_points.size() == 0) begin
				$error("point with no reading outstanding: world_x=%0d world_y=%0d slot=%0d",
					wx, wy, sl);
				failures++;
				return;
			end
			p = expected_points.pop_front();
			if (wx !== p.wx) begin
				$error("world_x: expected %0d, actual %0d", p.wx, wx);
				failures++;
			end
			if (wy !== p.wy) begin
				$error("world_y: expected %0d, actual %0d", p.wy, wy);
				failures++;
			end
			if (sl !== p.slot) begin
				$error("slot: expected %0d, actual %0d", p.slot, sl);
				failures++;
			end
			if (acc !== p.acc) begin
				$error("accepted: expected %0d, actual %0d", p.acc, acc);
				failures++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [RSW_SENSOR_W-1:0] sensor_index;
	logic [RSW_RAW_W-1:0]    distance;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic signed [RSW_COORD_W-1:0] world_x;
	logic signed [RSW_COORD_W-1:0] world_y;
	logic [RSW_SLOT_W-1:0]         slot;
	logic        accepted;

	world_point_tracker tracker = new();
	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	bit  hold_request   = 1'b0;
	logic rx_hold       = 1'b0;

	range_sensor_to_world_points dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sensor_index (sensor_index),
		.distance     (distance),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.world_x      (world_x),
		.world_y      (world_y),
		.slot         (slot),
		.accepted     (accepted)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// output side: check each beat, then pick next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_point(world_x, world_y, slot, accepted);
		out_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// long output hold-off, counted here so the sender keeps pushing
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rx_hold <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		end
	end

	// one reading beat, with random idle cycles ahead of it
	task automatic send_reading(input logic [2:0] s, input logic [15:0] d);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		sensor_index <= s;
		distance     <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_reading(s, d);
	endtask

	// stop sending, wait for every point, then let the pipeline settle
	task automatic drain_points();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all six registers, block idle
	task automatic apply_config(input logic [15:0] px, py, ch, sh, rlo, rhi);
		logic [15:0] vals [6];
		logic [2:0]  idx  [6];
		int          i;
		vals = '{px, py, ch, sh, rlo, rhi};
		idx  = '{REG_POSE_X, REG_POSE_Y, REG_COS, REG_SIN, REG_RANGE_MIN, REG_RANGE_MAX};
		for (i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			tracker.write_reg(idx[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// mostly in-range distances, with edges, small and full-width values
	function automatic logic [15:0] pick_distance();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55 && tracker.range_lo <= tracker.range_hi)
			return 16'($urandom_range(tracker.range_lo, tracker.range_hi));
		if (r < 70) begin
			case ($urandom_range(0, 3))
				0:       return {4'd0, tracker.range_lo};
				1:       return {4'd0, tracker.range_hi};
				2:       return {4'd0, tracker.range_lo} - 16'd1;
				default: return {4'd0, tracker.range_hi} + 16'd1;
			endcase
		end
		if (r < 85) return 16'($urandom_range(0, 4095));
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_rotation();
		if ($urandom_range(0, 9) < 8)
			return 16'($urandom_range(0, 32768)) - 16'd16384;
		return 16'($urandom);
	endfunction

	// main sequence
	initial begin
		int          i, p, count;
		logic [2:0]  s;
		logic [15:0] lo, hi;
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_POSE_X;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		sensor_index <= '0;
		distance     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, range edges and just above, per sensor, default setup
		for (i = 0; i < RSW_SENSORS; i++) begin
			send_reading(3'(i), 16'd0);
			send_reading(3'(i), 16'd1);
			send_reading(3'(i), 16'd2000);
			send_reading(3'(i), 16'd2001);
		end
		// unknown sensor indexes give no point
		for (i = RSW_SENSORS; i < 8; i++)
			send_reading(3'(i), 16'($urandom));
		send_reading(SENSOR_LEFT, 16'hFFFF);
		send_reading(SENSOR_FRONT, 16'hFFFF);
		drain_points();

		// random phases, idling mode cycles through none/sender/receiver/both
		for (p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			case (p)
				0: apply_config(16'd1500, -16'sd800, 16'sd11585, 16'sd11585,
					16'd50, 16'd3000);
				// saturation at both ends, full range incl. zero and 4095
				1: apply_config(16'h8000, 16'h7FFF, 16'sd16384, 16'sd0,
					16'd0, 16'd4095);
				2: apply_config(16'h7FFF, 16'h8000, 16'sd0, -16'sd16384,
					16'd100, 16'd100);
				// rotation beyond Q1.14 unity, empty range
				3: apply_config(16'd0, 16'd0, 16'h8000, 16'h7FFF,
					16'd3000, 16'd200);
				default: begin
					lo = 16'($urandom_range(0, 2000));
					hi = 16'($urandom_range(lo, 4095));
					apply_config(16'($urandom), 16'($urandom), pick_rotation(),
						pick_rotation(), lo, hi);
				end
			endcase
			count = 0;
			while (count < PHASE_READINGS) begin
				if ($urandom_range(0, 9) == 0)
					s = 3'($urandom_range(RSW_SENSORS, 7));
				else
					s = 3'($urandom_range(0, RSW_SENSORS - 1));
				send_reading(s, pick_distance());
				if (s < RSW_SENSORS) begin
					count++;
					if (p == 0 && count == 40) hold_request = 1'b1;
				end
			end
			drain_points();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule
